### design/tlm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the top-k list merge block.
// No dependencies; used by every module of the block but tlm_ram.
package tlm_pkg;

   localparam int ID_W        = 32;
   localparam int CNT_W       = 32;
   localparam int ENTRY_W     = ID_W + CNT_W;
   localparam int TOPK_W      = 7;
   localparam int MAX_TOPK_DEF = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [ID_W-1:0]   PAD_ID     = {ID_W{1'b1}};
   localparam logic [TOPK_W-1:0] TOPK_RESET = TOPK_W'(16);

   // register index of topk_in_use (byte address = 4 * index)
   localparam logic REG_TOPK_IN_USE = 1'b0;

   // merge command passed from the load side to the merge engine
   typedef struct packed {
      logic [TOPK_W-1:0] loaded;   // pairs stored in this run
      logic [TOPK_W-1:0] k;        // results to emit, already clamped
   } merge_cmd_type;

   typedef enum logic {
      MERGE_IDLE,
      MERGE_RUN
   } merge_state_type;

endpackage

### design/tlm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tlm_cmd_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of merge commands between the load side and the merge engine.
// Depends on tlm_pkg.
module tlm_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tlm_pkg::merge_cmd_type push_cmd,
   input  logic                   pop,
   output logic                   cmd_valid,
   output tlm_pkg::merge_cmd_type cmd
);
   import tlm_pkg::*;

   merge_cmd_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign do_push = push && (cnt_ff != 2'd2);
   assign do_pop  = pop && (cnt_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

endmodule

### design/tlm_front.sv
`timescale 1ns / 1ps
// Load side: accepts entry pairs, writes both lists and issues merge commands.
// Depends on tlm_pkg.
module tlm_front #(
   parameter int MAX_TOPK = tlm_pkg::MAX_TOPK_DEF,
   localparam int AW = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tlm_pkg::ID_W-1:0]    req_self_id,
   input  logic [tlm_pkg::CNT_W-1:0]   req_self_count,
   input  logic [tlm_pkg::ID_W-1:0]    req_recv_id,
   input  logic [tlm_pkg::CNT_W-1:0]   req_recv_count,
   input  logic                        req_last_entry,
   input  logic [tlm_pkg::TOPK_W-1:0]  topk_in_use,
   input  logic                        merge_done,
   output logic                        wr_en,
   output logic [AW-1:0]               wr_addr,
   output logic [tlm_pkg::ENTRY_W-1:0] self_wr_data,
   output logic [tlm_pkg::ENTRY_W-1:0] recv_wr_data,
   output logic                        cmd_push,
   output tlm_pkg::merge_cmd_type      cmd
);
   import tlm_pkg::*;

   localparam int PW = $clog2(MAX_TOPK + 1);

   logic [PW-1:0] load_ff, load_in;
   logic          lock_ff, lock_in;
   logic          accept;
   logic [PW-1:0] loaded;

   assign req_stall = lock_ff;
   assign accept    = req_valid && !req_stall;

   assign wr_en        = accept && (load_ff < PW'(MAX_TOPK));
   assign wr_addr      = load_ff[AW-1:0];
   assign self_wr_data = {req_self_id, req_self_count};
   assign recv_wr_data = {req_recv_id, req_recv_count};
   assign loaded       = wr_en ? load_ff + PW'(1) : load_ff;

   assign cmd_push   = accept && req_last_entry;

   // pass the loaded count on, clamp k into 1..MAX_TOPK
   always_comb begin
      cmd.loaded = TOPK_W'(loaded);
      priority if (topk_in_use == '0) begin
         cmd.k = TOPK_W'(1);
      end else if (topk_in_use > TOPK_W'(MAX_TOPK)) begin
         cmd.k = TOPK_W'(MAX_TOPK);
      end else begin
         cmd.k = topk_in_use;
      end
   end

   always_comb begin
      load_in = load_ff;
      lock_in = lock_ff;
      if (cmd_push) begin
         load_in = '0;
         lock_in = 1'b1;
      end else if (wr_en) begin
         load_in = loaded;
      end
      if (merge_done) begin
         lock_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
         lock_ff <= 1'b0;
      end else begin
         load_ff <= load_in;
         lock_ff <= lock_in;
      end
   end

endmodule

### design/tlm_back.sv
`timescale 1ns / 1ps
// Merge engine: walks both list heads, emits one result per cycle unless stalled.
// Depends on tlm_pkg; reads the list RAMs instantiated at the top level.
module tlm_back #(
   parameter int MAX_TOPK = tlm_pkg::MAX_TOPK_DEF,
   localparam int AW = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  tlm_pkg::merge_cmd_type      cmd,
   output logic                        cmd_pop,
   output logic [AW-1:0]               self_rd_addr,
   output logic [AW-1:0]               recv_rd_addr,
   input  logic [tlm_pkg::ENTRY_W-1:0] self_rd_data,
   input  logic [tlm_pkg::ENTRY_W-1:0] recv_rd_data,
   output logic                        merge_done,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tlm_pkg::ID_W-1:0]    rsp_merged_id,
   output logic [tlm_pkg::CNT_W-1:0]   rsp_merged_count,
   output logic                        rsp_last_result
);
   import tlm_pkg::*;

   localparam int PW = $clog2(MAX_TOPK + 1);

   merge_state_type state_ff, state_in;
   logic [PW-1:0]   ps_ff, ps_in, pr_ff, pr_in, pos_ff, pos_in;
   logic [PW-1:0]   loaded_ff, loaded_in, k_ff, k_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            last_ff, last_in;

   logic [ID_W-1:0]  s_id, r_id, pick_id;
   logic [CNT_W-1:0] s_cnt, r_cnt, pick_cnt;
   logic            s_pad, r_pad, recv_first, pick_pad;
   logic            out_free, step, last_pos;

   assign s_id  = self_rd_data[ENTRY_W-1:CNT_W];
   assign s_cnt = self_rd_data[CNT_W-1:0];
   assign r_id  = recv_rd_data[ENTRY_W-1:CNT_W];
   assign r_cnt = recv_rd_data[CNT_W-1:0];

   // positions past the loaded pairs read as pads
   assign s_pad = (ps_ff >= loaded_ff) || (s_id == PAD_ID);
   assign r_pad = (pr_ff >= loaded_ff) || (r_id == PAD_ID);
   assign recv_first = !r_pad && (s_pad || (r_cnt > s_cnt));

   assign pick_pad = recv_first ? r_pad : s_pad;
   assign pick_id  = recv_first ? r_id : s_id;
   assign pick_cnt = recv_first ? r_cnt : s_cnt;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step     = (state_ff == MERGE_RUN) && out_free;
   assign last_pos = (pos_ff + PW'(1)) == k_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MERGE_IDLE: if (cmd_valid) state_in = MERGE_RUN;
         MERGE_RUN:  if (step && last_pos) state_in = MERGE_IDLE;
         default:    state_in = MERGE_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      cmd_pop    = 1'b0;
      merge_done = 1'b0;
      unique case (state_ff)
         MERGE_IDLE: cmd_pop = cmd_valid;
         MERGE_RUN:  merge_done = step && last_pos;
         default:    cmd_pop = 1'b0;
      endcase
   end

   // pointers; the RAMs read at the next pointer so heads track ps_ff/pr_ff
   always_comb begin
      ps_in     = ps_ff;
      pr_in     = pr_ff;
      pos_in    = pos_ff;
      loaded_in = loaded_ff;
      k_in      = k_ff;
      if (state_ff == MERGE_IDLE) begin
         ps_in  = '0;
         pr_in  = '0;
         pos_in = '0;
         if (cmd_pop) begin
            loaded_in = PW'(cmd.loaded);
            k_in      = PW'(cmd.k);
         end
      end else if (step) begin
         ps_in  = recv_first ? ps_ff : ps_ff + PW'(1);
         pr_in  = recv_first ? pr_ff + PW'(1) : pr_ff;
         pos_in = pos_ff + PW'(1);
      end
   end

   assign self_rd_addr = ps_in[AW-1:0];
   assign recv_rd_addr = pr_in[AW-1:0];

   // output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      id_in        = id_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      if (out_free) begin
         rsp_valid_in = step;
         id_in        = pick_pad ? PAD_ID : pick_id;
         count_in     = pick_pad ? '0 : pick_cnt;
         last_in      = last_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= MERGE_IDLE;
         rsp_valid_ff <= 1'b0;
         ps_ff        <= '0;
         pr_ff        <= '0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ps_ff        <= ps_in;
         pr_ff        <= pr_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      loaded_ff <= loaded_in;
      k_ff      <= k_in;
      id_ff     <= id_in;
      count_ff  <= count_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_id    = id_ff;
   assign rsp_merged_count = count_ff;
   assign rsp_last_result  = last_ff;

endmodule

### design/topk_list_merge_top.sv
`timescale 1ns / 1ps
// Top level of the top-k list merge block: config register, list RAMs, load side,
// command queue, merge engine. Uses tlm_pkg and all tlm_ modules but tlm_checker.
//
// Usage:
//   Request channel (req_*): one word per list position, carrying entry i of
//   the local list and entry i of the received list, both sorted by count
//   high to low. Words without last_entry just store the pair (one per cycle
//   while req_stall is low); pairs beyond MAX_TOPK are dropped. The word with
//   last_entry stores its pair and launches a merge.
//   Response channel (rsp_*): k words, best count first, local entry wins ties,
//   pads (id all ones) rank below real entries and come out as id all ones,
//   count zero. last_result marks the k-th word. k is topk_in_use clamped
//   to 1..MAX_TOPK.
//   Timing: the last_entry word pushes a merge command into the queue; the
//   merge engine pops it and starts, and its first result word enters the
//   output register, then one result per cycle while rsp_stall is low, paced
//   by the single read port of each list RAM. req_stall stays high from the
//   last_entry word until the final result enters the output register.
//   Receiver stall: the output register holds its word and the merge freezes
//   in place; nothing is lost.
//   Reset: clears the load position, the queue, the merge engine and the
//   output valid, and sets topk_in_use to 16. List contents are not cleared;
//   positions not loaded in the current run read as pads.
//   CSR: APB, topk_in_use at byte addresses 0 to 3; addresses 4 to 7 read zero
//   and ignore writes. pready is always high.
module topk_list_merge_top #(
   parameter int MAX_TOPK = tlm_pkg::MAX_TOPK_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request words
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tlm_pkg::ID_W-1:0]       req_self_id,
   input  logic [tlm_pkg::CNT_W-1:0]      req_self_count,
   input  logic [tlm_pkg::ID_W-1:0]       req_recv_id,
   input  logic [tlm_pkg::CNT_W-1:0]      req_recv_count,
   input  logic                           req_last_entry,
   // response words
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tlm_pkg::ID_W-1:0]       rsp_merged_id,
   output logic [tlm_pkg::CNT_W-1:0]      rsp_merged_count,
   output logic                           rsp_last_result,
   // APB configuration
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tlm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tlm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tlm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import tlm_pkg::*;

   localparam int AW = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1;

   logic [TOPK_W-1:0] topk_ff, topk_in;
   logic              csr_wr, csr_hit;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [ENTRY_W-1:0] self_wr_data, recv_wr_data;
   logic [AW-1:0]     self_rd_addr, recv_rd_addr;
   logic [ENTRY_W-1:0] self_rd_data, recv_rd_data;
   logic              cmd_push, cmd_pop, cmd_valid, merge_done;
   merge_cmd_type     push_cmd, head_cmd;

   // config register; register index is paddr[2]
   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == REG_TOPK_IN_USE);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;
   assign topk_in = csr_wr ? pwdata[TOPK_W-1:0] : topk_ff;
   assign prdata  = csr_hit ? CSR_DATA_W'(topk_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         topk_ff <= TOPK_RESET;
      end else begin
         topk_ff <= topk_in;
      end
   end

   tlm_front #(.MAX_TOPK(MAX_TOPK)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_self_id    (req_self_id),
      .req_self_count (req_self_count),
      .req_recv_id    (req_recv_id),
      .req_recv_count (req_recv_count),
      .req_last_entry (req_last_entry),
      .topk_in_use    (topk_ff),
      .merge_done     (merge_done),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .self_wr_data   (self_wr_data),
      .recv_wr_data   (recv_wr_data),
      .cmd_push       (cmd_push),
      .cmd            (push_cmd)
   );

   // local list
   tlm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TOPK)) u_self_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (self_wr_data),
      .rd_addr (self_rd_addr),
      .rd_data (self_rd_data)
   );

   // received list
   tlm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TOPK)) u_recv_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (recv_wr_data),
      .rd_addr (recv_rd_addr),
      .rd_data (recv_rd_data)
   );

   tlm_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (push_cmd),
      .pop       (cmd_pop),
      .cmd_valid (cmd_valid),
      .cmd       (head_cmd)
   );

   tlm_back #(.MAX_TOPK(MAX_TOPK)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (head_cmd),
      .cmd_pop          (cmd_pop),
      .self_rd_addr     (self_rd_addr),
      .recv_rd_addr     (recv_rd_addr),
      .self_rd_data     (self_rd_data),
      .recv_rd_data     (recv_rd_data),
      .merge_done       (merge_done),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_id    (rsp_merged_id),
      .rsp_merged_count (rsp_merged_count),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

### design/tlm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the top-k list merge block, bound to the top level.
// Depends on tlm_pkg and topk_list_merge_top.
module tlm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_last_entry,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [tlm_pkg::ID_W-1:0]     rsp_merged_id,
   input logic [tlm_pkg::CNT_W-1:0]    rsp_merged_count,
   input logic                         rsp_last_result
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_merged_id)
         && $stable(rsp_merged_count) && $stable(rsp_last_result))
      else $error("stalled response word changed");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a last_entry word locks the request side
   a_lock_on_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_entry |=> req_stall)
      else $error("request side open right after last entry");

   // no new words are taken while a non-last result word is on the output
   a_no_load_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> req_stall)
      else $error("request accepted during a merge run");

endmodule

bind topk_list_merge_top tlm_checker u_tlm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last_entry   (req_last_entry),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_merged_id    (rsp_merged_id),
   .rsp_merged_count (rsp_merged_count),
   .rsp_last_result  (rsp_last_result)
);

### tb/topk_list_merge_checker.sv
`timescale 1ns / 1ps
// Checker for the top-k list merge block: follows the APB register and the
// request words, predicts each merge, and compares the response words in order.
// Depends on tlm_pkg only.
module topk_list_merge_checker #(
   parameter int MAX_TOPK = tlm_pkg::MAX_TOPK_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [tlm_pkg::ID_W-1:0]       req_self_id,
   input  logic [tlm_pkg::CNT_W-1:0]      req_self_count,
   input  logic [tlm_pkg::ID_W-1:0]       req_recv_id,
   input  logic [tlm_pkg::CNT_W-1:0]      req_recv_count,
   input  logic                           req_last_entry,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [tlm_pkg::ID_W-1:0]       rsp_merged_id,
   input  logic [tlm_pkg::CNT_W-1:0]      rsp_merged_count,
   input  logic                           rsp_last_result,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tlm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tlm_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [tlm_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                           pready,
   output int                             fail_count,
   output int                             pending,
   output int                             merges_done,
   output int                             results_checked
);
   import tlm_pkg::*;

   localparam int MAX_REPORTS = 10;
   localparam logic [CSR_ADDR_W-1:0] TOPK_ADDR = CSR_ADDR_W'(4 * REG_TOPK_IN_USE);

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [CNT_W-1:0] count;
   } list_entry_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [CNT_W-1:0] count;
      logic             last;
   } merged_word_type;

   list_entry_type         self_entries [MAX_TOPK];
   list_entry_type         recv_entries [MAX_TOPK];
   int                     pairs_loaded;
   logic [TOPK_W-1:0]      topk_setting;
   merged_word_type        merged_expect_q [$];
   merged_word_type        seen_word;
   merged_word_type        want_word;
   logic [CSR_DATA_W-1:0]  want_rdata;

   function automatic bit log_failure();
      fail_count++;
      return fail_count <= MAX_REPORTS;
   endfunction

   // Walk both list heads; positions not loaded in this run act as pads.
   task automatic predict_merge();
      int             k;
      int             ps;
      int             pr;
      list_entry_type s;
      list_entry_type r;
      list_entry_type pick;
      bit             take_recv;
      k  = int'(topk_setting);
      if (k < 1) k = 1;
      if (k > MAX_TOPK) k = MAX_TOPK;
      ps = 0;
      pr = 0;
      for (int pos = 0; pos < k; pos++) begin
         s = (ps < pairs_loaded) ? self_entries[ps]
                                 : list_entry_type'{id: PAD_ID, count: '0};
         r = (pr < pairs_loaded) ? recv_entries[pr]
                                 : list_entry_type'{id: PAD_ID, count: '0};
         if (r.id == PAD_ID) take_recv = 1'b0;
         else if (s.id == PAD_ID) take_recv = 1'b1;
         else take_recv = r.count > s.count;
         if (take_recv) begin
            pick = r;
            pr++;
         end else begin
            pick = s;
            ps++;
         end
         if (pick.id == PAD_ID) pick.count = '0;
         merged_expect_q.push_back(
            merged_word_type'{id: pick.id, count: pick.count, last: pos == k - 1});
      end
      merges_done++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pairs_loaded    = 0;
         topk_setting    = TOPK_RESET;
         merges_done     = 0;
         results_checked = 0;
         fail_count      = 0;
         merged_expect_q.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == TOPK_ADDR) topk_setting = pwdata[TOPK_W-1:0];
            end else begin
               want_rdata = (paddr == TOPK_ADDR) ? CSR_DATA_W'(topk_setting) : '0;
               if (prdata !== want_rdata && log_failure())
                  $display("csr read at %h: expected %h, got %h", paddr, want_rdata, prdata);
            end
         end

         if (rsp_valid && !rsp_stall) begin
            seen_word = '{id: rsp_merged_id, count: rsp_merged_count, last: rsp_last_result};
            results_checked++;
            if (merged_expect_q.size() == 0) begin
               if (log_failure())
                  $display("unexpected result word: id %h count %h last %b",
                           seen_word.id, seen_word.count, seen_word.last);
            end else begin
               want_word = merged_expect_q.pop_front();
               if ((seen_word.id !== want_word.id || seen_word.count !== want_word.count ||
                    seen_word.last !== want_word.last) && log_failure())
                  $display({"result mismatch: expected id %h count %h last %b,",
                            " got id %h count %h last %b"},
                           want_word.id, want_word.count, want_word.last,
                           seen_word.id, seen_word.count, seen_word.last);
            end
         end

         if (req_valid && !req_stall) begin
            // drop pairs past the list depth
            if (pairs_loaded < MAX_TOPK) begin
               self_entries[pairs_loaded] = '{id: req_self_id, count: req_self_count};
               recv_entries[pairs_loaded] = '{id: req_recv_id, count: req_recv_count};
               pairs_loaded++;
            end
            if (req_last_entry) begin
               predict_merge();
               pairs_loaded = 0;
            end
         end
      end
      pending <= merged_expect_q.size();
   end

endmodule

### tb/topk_list_merge_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the top-k list merge block: clock, reset, request and
// response traffic, APB register writes and the verdict.
// Depends on tlm_pkg, topk_list_merge_top and topk_list_merge_checker.
module topk_list_merge_top_test;
   import tlm_pkg::*;

   localparam int MAX_TOPK        = MAX_TOPK_DEF;
   localparam int WORDS_PER_PHASE = 30;
   localparam int SETTLE_CYCLES   = 8;
   localparam int LONG_HOLD       = 300;
   localparam int QUIET_LIMIT     = 3000;
   localparam logic [CSR_ADDR_W-1:0] TOPK_ADDR  = CSR_ADDR_W'(4 * REG_TOPK_IN_USE);
   // next register slot; not implemented, so writes drop and reads give zero
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4 * (REG_TOPK_IN_USE + 1));

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [ID_W-1:0]       req_self_id;
   logic [CNT_W-1:0]      req_self_count;
   logic [ID_W-1:0]       req_recv_id;
   logic [CNT_W-1:0]      req_recv_count;
   logic                  req_last_entry;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ID_W-1:0]       rsp_merged_id;
   logic [CNT_W-1:0]      rsp_merged_count;
   logic                  rsp_last_result;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int pending;
   int merges_done;
   int results_checked;

   // knobs and counters of the sender, receiver and watchdog processes
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;
   int words_offered = 0;
   int quiet_cycles  = 0;

   topk_list_merge_top #(.MAX_TOPK(MAX_TOPK)) dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_self_id, .req_self_count,
      .req_recv_id, .req_recv_count, .req_last_entry,
      .rsp_valid, .rsp_stall, .rsp_merged_id, .rsp_merged_count, .rsp_last_result,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   topk_list_merge_checker #(.MAX_TOPK(MAX_TOPK)) u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_self_id, .req_self_count,
      .req_recv_id, .req_recv_count, .req_last_entry,
      .rsp_valid, .rsp_stall, .rsp_merged_id, .rsp_merged_count, .rsp_last_result,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .fail_count, .pending, .merges_done, .results_checked
   );

   always #5 clock = ~clock;

   // Receiver: a long hold-off counts itself down here; otherwise stall at
   // random with the current phase's percentage.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog: end the run if no word and no register access moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Count steps shrink so each list stays sorted high to low; the narrow
   // mode keeps counts small so the two lists tie often.
   function automatic logic [CNT_W-1:0] lower_count(logic [CNT_W-1:0] c, bit narrow);
      logic [CNT_W-1:0] step;
      step = narrow ? CNT_W'($urandom_range(3)) : CNT_W'($urandom_range(32'h0FFF_FFFF));
      return (c > step) ? c - step : '0;
   endfunction

   // Mostly random ids, with the all-zero id, the id just below a pad, and a
   // stray pad mixed in.
   function automatic logic [ID_W-1:0] pick_id();
      case ($urandom_range(15))
         0: return '0;
         1: return PAD_ID - 1;
         2: return PAD_ID;
         default: return $urandom;
      endcase
   endfunction

   // Offer one word after a random idle gap, and hold it until accepted.
   task automatic offer_pair(logic [ID_W-1:0] s_id, logic [CNT_W-1:0] s_cnt,
                             logic [ID_W-1:0] r_id, logic [CNT_W-1:0] r_cnt, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_self_id    <= s_id;
      req_self_count <= s_cnt;
      req_recv_id    <= r_id;
      req_recv_count <= r_cnt;
      req_last_entry <= last;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall);
      words_offered++;
   endtask

   // One run of len pairs, last_entry on the final one. A tidy run keeps both
   // lists sorted and lets each list run out into pads; otherwise send noise.
   task automatic offer_lists(int len, bit tidy);
      logic [CNT_W-1:0] s_cnt;
      logic [CNT_W-1:0] r_cnt;
      bit               s_done;
      bit               r_done;
      bit               narrow;
      narrow = $urandom_range(1);
      s_cnt  = narrow ? CNT_W'($urandom_range(40)) : CNT_W'($urandom);
      r_cnt  = narrow ? CNT_W'($urandom_range(40)) : CNT_W'($urandom);
      s_done = 1'b0;
      r_done = 1'b0;
      for (int i = 0; i < len; i++) begin
         if (tidy) begin
            if (i > 0) begin
               s_cnt = lower_count(s_cnt, narrow);
               r_cnt = lower_count(r_cnt, narrow);
            end
            if ($urandom_range(11) == 0) s_done = 1'b1;
            if ($urandom_range(11) == 0) r_done = 1'b1;
            offer_pair(s_done ? PAD_ID : pick_id(), s_cnt,
                       r_done ? PAD_ID : pick_id(), r_cnt, i == len - 1);
         end else begin
            offer_pair(pick_id(), $urandom, pick_id(), $urandom, i == len - 1);
         end
      end
   endtask

   // Wait until every predicted result has come back, then let the block settle.
   task automatic settle();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup phase, access phase until pready, then psel drops to idle.
   task automatic csr_access(bit wr, logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // One random phase: reprogram topk while idle, set the idling mix, then
   // send runs until the word budget is spent.
   task automatic run_phase(int idle_pct, int stall_pct, logic [CSR_DATA_W-1:0] topk_word,
                            int hold, bit drain_often);
      int eff;
      int placed;
      int len;
      settle();
      csr_access(1'b1, TOPK_ADDR, topk_word);
      csr_access(1'b0, TOPK_ADDR, '0);
      eff = int'(topk_word[TOPK_W-1:0]);
      if (eff < 1) eff = 1;
      if (eff > MAX_TOPK) eff = MAX_TOPK;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      hold_left     = hold;
      placed = 0;
      while (placed < WORDS_PER_PHASE) begin
         // a few runs overflow the list depth; the rest fit within topk
         len = ($urandom_range(9) == 0) ? $urandom_range(MAX_TOPK + 1, MAX_TOPK + 4)
                                        : $urandom_range(1, eff);
         offer_lists(len, $urandom_range(4) != 0);
         placed += len;
         if (drain_often && $urandom_range(2) == 0) begin
            // pause the sender until the merge output has fully drained
            req_valid <= 1'b0;
            settle();
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      logic [CNT_W-1:0] s_cnt;
      logic [CNT_W-1:0] r_cnt;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_self_id    <= '0;
      req_self_count <= '0;
      req_recv_id    <= '0;
      req_recv_count <= '0;
      req_last_entry <= 1'b0;
      rsp_stall      <= 1'b0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed, topk at its reset value: a count tie (local wins), a real
      // entry beating a pad that carries the top count, two pads head to head,
      // and a short run filled out with pads.
      offer_pair('0, '1, PAD_ID - 1, '1, 1'b0);
      offer_pair(32'h1234_5678, 32'h8000_0000, PAD_ID, '1, 1'b0);
      offer_pair(PAD_ID, 32'h0000_0009, 32'h0000_0001, '0, 1'b0);
      offer_pair(PAD_ID, 32'h0000_0007, PAD_ID, 32'h0000_0007, 1'b1);
      req_valid <= 1'b0;
      settle();

      // Read the reset value, check the spare slot drops writes, then topk of
      // zero acts as one.
      csr_access(1'b0, TOPK_ADDR, '0);
      csr_access(1'b1, SPARE_ADDR, 32'h0000_0003);
      csr_access(1'b0, SPARE_ADDR, '0);
      csr_access(1'b0, TOPK_ADDR, '0);
      csr_access(1'b1, TOPK_ADDR, 32'h0000_0000);
      offer_pair(PAD_ID - 1, '0, 32'h0000_0001, 32'h0000_0001, 1'b1);
      req_valid <= 1'b0;
      settle();

      // topk of 127 clamps to the list depth; overflow the lists by two pairs.
      csr_access(1'b1, TOPK_ADDR, 32'hFFFF_FF7F);
      csr_access(1'b0, TOPK_ADDR, '0);
      s_cnt = '1;
      r_cnt = 32'hFFFF_FFF0;
      for (int i = 0; i < MAX_TOPK + 2; i++) begin
         offer_pair($urandom, s_cnt, $urandom, r_cnt, i == MAX_TOPK + 1);
         s_cnt = lower_count(s_cnt, 1'b0);
         r_cnt = lower_count(r_cnt, 1'b0);
      end
      req_valid <= 1'b0;

      // Random phases: no idling, sender idle, receiver stalling, both lightly,
      // then a long receiver hold-off with sender pauses and an odd topk.
      run_phase(0, 0, 32'd5, 0, 1'b0);
      run_phase(88, 0, 32'hFFFF_FF90, 0, 1'b0);
      run_phase(0, 88, 32'd64, 0, 1'b0);
      run_phase(11, 11, 32'd1, 0, 1'b0);
      run_phase(0, 0, ($urandom & 32'hFFFF_FF80) | $urandom_range(1, 20), LONG_HOLD, 1'b1);

      settle();
      repeat (2 * MAX_TOPK) @(posedge clock);
      $display("covered %0d request words, %0d merges, %0d result words checked", words_offered,
               merges_done, results_checked);
      $display("topk settings 0, 1, 5, 16, 64, 127 and a random one, with ties, pads and overflow");
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d failures, %0d results still expected", fail_count, pending);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
